### src/sjis_pkg.sv
`timescale 1ns / 1ps

package sjis_pkg;

  localparam int unsigned LEN_SAT    = 65535;
  localparam int unsigned CNT_W      = $clog2(LEN_SAT + 1);
  localparam int unsigned ORDER_W    = 17;
  localparam int unsigned ORDER_LIM  = 65535;
  localparam int unsigned DIFF_W     = (CNT_W + 1 > ORDER_W + 1) ? CNT_W + 1 : ORDER_W + 1;

  localparam logic [7:0] LEAD_LO1  = 8'h81;
  localparam logic [7:0] LEAD_HI1  = 8'h9f;
  localparam logic [7:0] LEAD_LO2  = 8'he0;
  localparam logic [7:0] LEAD_HI2  = 8'hfc;
  localparam logic [7:0] TRAIL_LO1 = 8'h40;
  localparam logic [7:0] TRAIL_HI1 = 8'h7e;
  localparam logic [7:0] TRAIL_LO2 = 8'h80;
  localparam logic [7:0] TRAIL_HI2 = 8'hfc;
  localparam logic [7:0] LOWER_LO  = 8'h61;
  localparam logic [7:0] LOWER_HI  = 8'h7a;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef struct packed {
    logic       has;
    logic       is_lead;
    logic       is_trail;
    logic [7:0] folded;
  } lane_info_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    return (c >= LOWER_LO && c <= LOWER_HI) ? c - CASE_GAP : c;
  endfunction

  function automatic logic [ORDER_W-1:0] single_diff(input logic [7:0] fa,
                                                     input logic [7:0] fb);
    logic [8:0] d;
    d = {1'b0, fa} - {1'b0, fb};
    return {{(ORDER_W - 9){d[8]}}, d};
  endfunction

endpackage

### src/sjis_collation_compare.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | byte_a_i has_a_i byte_b_i has_b_i last_i
// out     | output    | out_valid_o/out_ready_i | order_value_o by_length_o
//
// One input transaction per cycle while in_ready_o is high; each position is folded into the state
// in the cycle it is taken, by the combinational compare over the held lead pair.
// The result is registered and appears the cycle after the transaction marked last.
// Reset clears all compare state and counts; no clearing pass.
// Input stalls only while a result waits in the output register and out_ready_i is low.

module sjis_collation_compare import sjis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_a_i,
  input  logic               has_a_i,
  input  logic [7:0]         byte_b_i,
  input  logic               has_b_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ORDER_W-1:0] order_value_o,
  output logic               by_length_o
);

  logic               step;
  lane_info_t         lane_a, lane_b;
  logic [CNT_W-1:0]   cnt_a, cnt_b;
  logic [ORDER_W-1:0] order;
  logic               by_length;
  logic               out_valid_q, out_valid_d;
  logic [ORDER_W-1:0] order_q;
  logic               by_length_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  sjis_lane u_lane_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_a_i),
    .has_i       (has_a_i),
    .step_i      (step),
    .clear_i     (last_i),
    .info_o      (lane_a),
    .count_nxt_o (cnt_a)
  );

  sjis_lane u_lane_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_b_i),
    .has_i       (has_b_i),
    .step_i      (step),
    .clear_i     (last_i),
    .info_o      (lane_b),
    .count_nxt_o (cnt_b)
  );

  sjis_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .last_i      (last_i),
    .byte_a_i    (byte_a_i),
    .byte_b_i    (byte_b_i),
    .lane_a_i    (lane_a),
    .lane_b_i    (lane_b),
    .cnt_a_i     (cnt_a),
    .cnt_b_i     (cnt_b),
    .order_o     (order),
    .by_length_o (by_length)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step && last_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_i) begin
      order_q     <= order;
      by_length_q <= by_length;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign order_value_o = order_q;
  assign by_length_o   = by_length_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_i |=> out_valid_o)
    else $error("terminating transaction produced no result");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(step && last_i))
    else $error("result appeared without a terminating transaction");

  a_length_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && by_length_o |-> order_value_o != {1'b1, {(ORDER_W - 1){1'b0}}})
    else $error("length difference out of range");

endmodule

### src/sjis_lane.sv
`timescale 1ns / 1ps

module sjis_lane import sjis_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       byte_i,
  input  logic             has_i,
  input  logic             step_i,
  input  logic             clear_i,
  output lane_info_t       info_o,
  output logic [CNT_W-1:0] count_nxt_o
);

  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    info_o.has      = has_i;
    info_o.is_lead  = (byte_i >= LEAD_LO1 && byte_i <= LEAD_HI1) ||
                      (byte_i >= LEAD_LO2 && byte_i <= LEAD_HI2);
    info_o.is_trail = (byte_i >= TRAIL_LO1 && byte_i <= TRAIL_HI1) ||
                      (byte_i >= TRAIL_LO2 && byte_i <= TRAIL_HI2);
    info_o.folded   = fold_byte(byte_i);
  end

  always_comb begin
    count_nxt_o = count_q;
    if (has_i && count_q != CNT_W'(LEN_SAT)) begin
      count_nxt_o = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (step_i) begin
      count_d = clear_i ? '0 : count_nxt_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

### src/sjis_merge.sv
`timescale 1ns / 1ps

module sjis_merge import sjis_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               last_i,
  input  logic [7:0]         byte_a_i,
  input  logic [7:0]         byte_b_i,
  input  lane_info_t         lane_a_i,
  input  lane_info_t         lane_b_i,
  input  logic [CNT_W-1:0]   cnt_a_i,
  input  logic [CNT_W-1:0]   cnt_b_i,
  output logic [ORDER_W-1:0] order_o,
  output logic               by_length_o
);

  logic [7:0]         held_a_q, held_a_d, held_b_q, held_b_d;
  logic               held_valid_q, held_valid_d;
  logic               decided_q, decided_d;
  logic [ORDER_W-1:0] found_q, found_d;
  logic               stopped_q, stopped_d;

  logic               both, trail_ok, lead_ok, consumed, held_set;
  logic [ORDER_W-1:0] code_diff, held_diff, cur_diff, fin_diff;
  logic               fin_decided;
  logic [DIFF_W-1:0]  len_diff;

  assign both      = lane_a_i.has && lane_b_i.has;
  assign trail_ok  = both && lane_a_i.is_trail && lane_b_i.is_trail;
  assign lead_ok   = lane_a_i.is_lead && lane_b_i.is_lead;
  assign code_diff = {1'b0, held_a_q, byte_a_i} - {1'b0, held_b_q, byte_b_i};
  assign held_diff = single_diff(fold_byte(held_a_q), fold_byte(held_b_q));
  assign cur_diff  = single_diff(lane_a_i.folded, lane_b_i.folded);

  always_comb begin
    held_a_d     = held_a_q;
    held_b_d     = held_b_q;
    held_valid_d = held_valid_q;
    decided_d    = decided_q;
    found_d      = found_q;
    stopped_d    = stopped_q;
    consumed     = 1'b0;
    held_set     = 1'b0;
    if (!decided_q && !stopped_q) begin
      if (held_valid_q) begin
        held_valid_d = 1'b0;
        if (trail_ok) begin
          consumed = 1'b1;
          if (code_diff != '0) begin
            decided_d = 1'b1;
            found_d   = code_diff;
          end
        end else if (held_diff != '0) begin
          decided_d = 1'b1;
          found_d   = held_diff;
        end
      end
      if (!consumed && !decided_d) begin
        if (!both) begin
          stopped_d = 1'b1;
        end else if (lead_ok) begin
          held_a_d     = byte_a_i;
          held_b_d     = byte_b_i;
          held_valid_d = 1'b1;
          held_set     = 1'b1;
        end else if (cur_diff != '0) begin
          decided_d = 1'b1;
          found_d   = cur_diff;
        end
      end
    end
  end

  // pending lead at the end of the pair falls back to a single-byte compare
  always_comb begin
    fin_decided = decided_d;
    fin_diff    = found_d;
    if (held_valid_d && !decided_d) begin
      if (held_set) begin
        fin_decided = (cur_diff != '0);
        fin_diff    = cur_diff;
      end else begin
        fin_decided = (held_diff != '0);
        fin_diff    = held_diff;
      end
    end
  end

  assign len_diff = DIFF_W'(cnt_a_i) - DIFF_W'(cnt_b_i);

  always_comb begin
    by_length_o = !fin_decided;
    order_o     = fin_diff;
    if (!fin_decided) begin
      if ($signed(len_diff) > $signed(DIFF_W'(ORDER_LIM))) begin
        order_o = ORDER_W'(ORDER_LIM);
      end else if ($signed(len_diff) < -$signed(DIFF_W'(ORDER_LIM))) begin
        order_o = -ORDER_W'(ORDER_LIM);
      end else begin
        order_o = len_diff[ORDER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_a_q     <= '0;
      held_b_q     <= '0;
      held_valid_q <= 1'b0;
      decided_q    <= 1'b0;
      found_q      <= '0;
      stopped_q    <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        held_a_q     <= '0;
        held_b_q     <= '0;
        held_valid_q <= 1'b0;
        decided_q    <= 1'b0;
        found_q      <= '0;
        stopped_q    <= 1'b0;
      end else begin
        held_a_q     <= held_a_d;
        held_b_q     <= held_b_d;
        held_valid_q <= held_valid_d;
        decided_q    <= decided_d;
        found_q      <= found_d;
        stopped_q    <= stopped_d;
      end
    end
  end

endmodule

### tb/tb_sjis_collation_compare.sv
`timescale 1ns / 1ps

module tb_sjis_collation_compare;
  import sjis_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned STALL_LEN   = 400;

  typedef struct packed {
    logic [7:0] a;
    logic       ha;
    logic [7:0] b;
    logic       hb;
    logic       last;
  } pos_t;

  typedef struct packed {
    logic [ORDER_W-1:0] value;
    logic               by_len;
  } order_t;

  typedef struct {
    pos_t   pos;
    bit     typed;
    order_t want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         byte_a_i;
  logic               has_a_i;
  logic [7:0]         byte_b_i;
  logic               has_b_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ORDER_W-1:0] order_value_o;
  logic               by_length_o;

  sjis_collation_compare dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_a_i      (byte_a_i),
    .has_a_i       (has_a_i),
    .byte_b_i      (byte_b_i),
    .has_b_i       (has_b_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .order_value_o (order_value_o),
    .by_length_o   (by_length_o)
  );

  always #6 clk_i = ~clk_i;

  order_t      orders_due[$];
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  int unsigned sent         = 0;
  int unsigned src_gap_pct  = 30;
  int unsigned sink_gap_pct = 53;
  bit          stall_request = 1'b0;
  int unsigned stall_left   = 0;

  // collation state
  logic [7:0]  pend_a, pend_b;
  bit          pend_v, diff_seen, halted;
  int          diff_val;
  int unsigned len_a, len_b;

  function automatic bit lead_byte(input logic [7:0] c);
    return (c >= LEAD_LO1 && c <= LEAD_HI1) || (c >= LEAD_LO2 && c <= LEAD_HI2);
  endfunction

  function automatic bit trail_byte(input logic [7:0] c);
    return (c >= TRAIL_LO1 && c <= TRAIL_HI1) || (c >= TRAIL_LO2 && c <= TRAIL_HI2);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] lead_pick();
    return $urandom_range(0, 1) ? 8'($urandom_range(LEAD_LO1, LEAD_HI1))
                                : 8'($urandom_range(LEAD_LO2, LEAD_HI2));
  endfunction

  function automatic logic [7:0] trail_pick();
    return $urandom_range(0, 1) ? 8'($urandom_range(TRAIL_LO1, TRAIL_HI1))
                                : 8'($urandom_range(TRAIL_LO2, TRAIL_HI2));
  endfunction

  function automatic row_t mk(input logic [7:0] a, input logic ha, input logic [7:0] b,
                              input logic hb, input logic lst, input bit typed = 1'b0,
                              input int value = 0, input bit by_len = 1'b0);
    row_t r;
    r.pos   = {a, ha, b, hb, lst};
    r.typed = typed;
    r.want  = {value[ORDER_W-1:0], by_len};
    return r;
  endfunction

  task automatic single_cmp(input logic [7:0] a, input logic [7:0] b);
    int d;
    d = int'(upcase(a)) - int'(upcase(b));
    if (d != 0) begin
      diff_seen = 1'b1;
      diff_val  = d;
    end
  endtask

  task automatic clear_collation();
    pend_a = '0; pend_b = '0; pend_v = 1'b0;
    diff_seen = 1'b0; halted = 1'b0; diff_val = 0;
    len_a = 0; len_b = 0;
  endtask

  task automatic collate_step(input pos_t p, output bit produced, output order_t r);
    int  ca, cb, v;
    bit  both, took;
    both     = p.ha && p.hb;
    took     = 1'b0;
    produced = 1'b0;
    r        = '0;
    if (!diff_seen && !halted) begin
      if (pend_v) begin
        pend_v = 1'b0;
        if (both && trail_byte(p.a) && trail_byte(p.b)) begin
          ca = {pend_a, p.a};
          cb = {pend_b, p.b};
          if (ca != cb) begin
            diff_seen = 1'b1;
            diff_val  = ca - cb;
          end
          took = 1'b1;
        end else begin
          single_cmp(pend_a, pend_b);
        end
      end
      if (!took && !diff_seen) begin
        if (!both) begin
          halted = 1'b1;
        end else if (lead_byte(p.a) && lead_byte(p.b)) begin
          pend_a = p.a;
          pend_b = p.b;
          pend_v = 1'b1;
        end else begin
          single_cmp(p.a, p.b);
        end
      end
    end
    if (p.ha && len_a < LEN_SAT) len_a++;
    if (p.hb && len_b < LEN_SAT) len_b++;
    if (p.last) begin
      if (pend_v && !diff_seen) single_cmp(pend_a, pend_b);
      if (diff_seen) begin
        v        = diff_val;
        r.by_len = 1'b0;
      end else begin
        v = int'(len_a) - int'(len_b);
        if (v > int'(ORDER_LIM)) v = ORDER_LIM;
        if (v < -int'(ORDER_LIM)) v = -int'(ORDER_LIM);
        r.by_len = 1'b1;
      end
      r.value  = v[ORDER_W-1:0];
      produced = 1'b1;
      clear_collation();
    end
  endtask

  task automatic offer_position(input pos_t p, input bit use_typed = 1'b0,
                                input order_t fixed = '0);
    bit     produced;
    order_t r;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_a_i   <= p.a;
    has_a_i    <= p.ha;
    byte_b_i   <= p.b;
    has_b_i    <= p.hb;
    last_i     <= p.last;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    collate_step(p, produced, r);
    if (produced) orders_due.push_back(use_typed ? fixed : r);
  endtask

  task automatic drive_strings(input logic [7:0] sa[$], input logic [7:0] sb[$]);
    int   n;
    pos_t p;
    n = (sa.size() > sb.size()) ? sa.size() : sb.size();
    if (n == 0) n = 1;
    for (int i = 0; i < n; i++) begin
      p.ha   = i < sa.size();
      p.hb   = i < sb.size();
      p.a    = p.ha ? sa[i] : 8'($urandom);
      p.b    = p.hb ? sb[i] : 8'($urandom);
      p.last = (i == n - 1);
      offer_position(p);
    end
  endtask

  task automatic random_pair();
    logic [7:0] sa[$], sb[$];
    int         n, k;
    pos_t       p;
    if ($urandom_range(0, 9) == 0) begin
      // noise: random flags, flags may return to 1
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        p = {8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), i == n - 1};
        offer_position(p);
      end
      return;
    end
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 3))
        0: sa.push_back(8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A"));
        1: begin
          sa.push_back(lead_pick());
          sa.push_back(trail_pick());
        end
        2: sa.push_back(8'($urandom));
        default: sa.push_back(lead_pick());
      endcase
    end
    sb = sa;
    foreach (sb[i]) begin
      if ((sb[i] | 8'h20) >= "a" && (sb[i] | 8'h20) <= "z" && $urandom_range(0, 1))
        sb[i] ^= 8'h20;
    end
    if (sb.size() > 0 && $urandom_range(0, 99) < 40) begin
      k = $urandom_range(0, sb.size() - 1);
      sb[k] = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                          : sb[k] + ($urandom_range(0, 1) ? 8'd1 : 8'd255);
    end
    case ($urandom_range(0, 5))
      0: if (sb.size() > 0) void'(sb.pop_back());
      1: sb.push_back(8'($urandom));
      2: if (sa.size() > 0) void'(sa.pop_back());
      default: ;
    endcase
    drive_strings(sa, sb);
  endtask

  task automatic long_pair(input int la, input int lb);
    logic [7:0] sa[$], sb[$];
    repeat (la) sa.push_back("k");
    repeat (lb) sb.push_back("k");
    drive_strings(sa, sb);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (orders_due.size() == 0);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sjis_collation_compare: mismatch");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left    = STALL_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= sink_gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check
    order_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (orders_due.size() == 0) begin
        $display("%0t: unexpected transaction, order_value %0d by_length %0b", $time,
                 $signed(order_value_o), by_length_o);
        mismatches++;
      end else begin
        want = orders_due.pop_front();
        if (order_value_o !== want.value) begin
          $display("%0t: order_value expected %0d actual %0d", $time,
                   $signed(want.value), $signed(order_value_o));
          mismatches++;
        end
        if (by_length_o !== want.by_len) begin
          $display("%0t: by_length expected %0b actual %0b", $time, want.by_len,
                   by_length_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    row_t plan[$];
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    byte_a_i   = '0;
    has_a_i    = 1'b0;
    byte_b_i   = '0;
    has_b_i    = 1'b0;
    last_i     = 1'b0;
    clear_collation();

    plan.push_back(mk(8'h00, 1, 8'h00, 1, 1, 1, 0, 1));
    plan.push_back(mk(8'hff, 1, 8'h00, 1, 1, 1, 255, 0));
    plan.push_back(mk(8'h00, 1, 8'hff, 1, 1, 1, -255, 0));
    plan.push_back(mk("a", 1, "A", 1, 0));
    plan.push_back(mk("z", 1, "Z", 1, 1, 1, 0, 1));
    plan.push_back(mk(8'h81, 1, 8'h81, 1, 0));
    plan.push_back(mk(8'h40, 1, 8'h41, 1, 1, 1, -1, 0));
    plan.push_back(mk(8'hfc, 1, 8'he0, 1, 0));
    plan.push_back(mk(8'hfc, 1, 8'h7e, 1, 1));
    // lead pair pending at the end mark
    plan.push_back(mk(8'he0, 1, 8'h81, 1, 1));
    // lead pair followed by non-trail
    plan.push_back(mk(8'h81, 1, 8'h81, 1, 0));
    plan.push_back(mk(8'h20, 1, 8'h30, 1, 1));
    // presence flag drops and returns
    plan.push_back(mk(8'h41, 1, 8'h41, 1, 0));
    plan.push_back(mk(8'h00, 0, 8'h42, 1, 0));
    plan.push_back(mk(8'h43, 1, 8'h44, 1, 1));
    plan.push_back(mk(8'h00, 0, 8'h00, 0, 1, 1, 0, 1));
    plan.push_back(mk(8'h9f, 1, 8'h9f, 1, 0));
    plan.push_back(mk(8'h80, 1, 8'hfc, 1, 0));
    plan.push_back(mk(8'h7b, 1, 8'h60, 1, 1));
    plan.push_back(mk(8'h41, 1, 8'h00, 0, 1, 1, 1, 1));
    plan.push_back(mk(8'he0, 1, 8'he0, 1, 0));
    plan.push_back(mk(8'h40, 0, 8'h40, 1, 1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer_position(plan[i].pos, plan[i].typed, plan[i].want);

    while (sent < 540) random_pair();
    drain();

    src_gap_pct  = 53;
    sink_gap_pct = 30;
    while (sent < 1080) random_pair();
    drain();

    src_gap_pct  = 0;
    sink_gap_pct = 0;
    // receiver holds off; input backs up behind the held result
    stall_request = 1'b1;
    repeat (8) random_pair();
    while (sent < 1520) random_pair();
    drain();

    // longer strings decided by length
    long_pair(43, 3);
    long_pair(2, 45);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sjis_collation_compare: match");
    end else begin
      $display("sjis_collation_compare: mismatch");
    end
    $finish;
  end

endmodule
